// ----- sv/rpi_pkg.sv -----
// Shared types and constants for the Rayleigh power iteration unit.
// Used by rpi_dpath, rpi_ctrl and rayleigh_power_iteration_unit; no dependencies.
`default_nettype none

package rpi_pkg;

  localparam int MAX_DIM = 16;
  localparam int IDX_W   = 4;
  localparam int SIZE_W  = 5;
  localparam int VAL_W   = 32;
  localparam int Y_W     = 52;
  localparam int ACC_W   = 68;
  localparam int LAM_W   = 88;
  localparam int EIG_W   = 48;
  localparam int CNT_W   = 7;

  // Input item kinds.
  localparam logic [1:0] FN_MAT   = 2'd0;
  localparam logic [1:0] FN_VEC   = 2'd1;
  localparam logic [1:0] FN_START = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SIZE  = 2'd0;
  localparam logic [1:0] CFG_TOL   = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD_MAT, DP_LOAD_VEC, DP_CLR_RUN, DP_NRM_CLR, DP_NRM_OR,
    DP_LOD_STEP, DP_M_SET, DP_SQ, DP_SQ_ACC, DP_SQRT_INIT, DP_SQRT_STEP,
    DP_DIV_INIT, DP_DIV_STEP, DP_DIV_WR, DP_ZERO_WR, DP_MAT_RD, DP_MAT_MUL,
    DP_MAT_ACC, DP_Y_WR, DP_LAM_MLO, DP_LAM_ALO, DP_LAM_MHI, DP_LAM_AHI,
    DP_EIG, DP_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } cmd_t;

  typedef struct packed {
    logic             orv_zero;
    logic             orv_msb;
    logic             err_ok;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

`default_nettype wire

// ----- sv/rpi_dpath.sv -----
// Datapath of the power iteration unit: matrix memory, vector registers,
// multiplier, accumulators, square root and divider steps. Depends on rpi_pkg.
`default_nettype none

module rpi_dpath (
  input  logic                                clk,
  input  rpi_pkg::cmd_t                       cmd,
  input  logic [rpi_pkg::VAL_W-1:0]           load_value,
  input  logic [31:0]                         tol,
  output rpi_pkg::stat_t                      stat,
  output logic signed [rpi_pkg::VAL_W-1:0]    x_out,
  output logic signed [rpi_pkg::EIG_W-1:0]    eig_out
);

  logic [rpi_pkg::VAL_W-1:0]        mat_mem [rpi_pkg::MAX_DIM*rpi_pkg::MAX_DIM];
  logic signed [rpi_pkg::VAL_W-1:0] mat_q;
  logic signed [rpi_pkg::VAL_W-1:0] xv [rpi_pkg::MAX_DIM];
  logic signed [rpi_pkg::Y_W-1:0]   yv [rpi_pkg::MAX_DIM];

  logic signed [rpi_pkg::ACC_W-1:0] acc;
  logic signed [63:0]               prod;
  logic signed [rpi_pkg::LAM_W-1:0] lam;
  logic signed [rpi_pkg::EIG_W-1:0] eig;
  logic signed [rpi_pkg::EIG_W-1:0] prev;
  logic [rpi_pkg::CNT_W-1:0]        count;
  logic                             err_ok;
  logic [rpi_pkg::Y_W-1:0]          orv;
  logic [5:0]                       lz;
  logic [28:0]                      m_r;
  logic [61:0]                      sum;
  logic [62:0]                      sq_s;
  logic [62:0]                      sq_res;
  logic [62:0]                      sq_bit;
  logic [31:0]                      rem;
  logic [30:0]                      quo;
  logic                             feed;

  logic signed [rpi_pkg::VAL_W-1:0] x_i;
  logic signed [rpi_pkg::VAL_W-1:0] x_j;
  logic signed [rpi_pkg::Y_W-1:0]   y_i;
  logic                             y_neg;
  logic [rpi_pkg::Y_W-1:0]          y_mag;
  logic                             shr;
  logic [4:0]                       sh_r;
  logic [4:0]                       sh_l;
  logic [28:0]                      m_next;
  logic signed [63:0]               p_mat;
  logic signed [63:0]               p_lo;
  logic signed [63:0]               p_hi;
  logic [57:0]                      p_sq;
  logic signed [32:0]               y_lo;
  logic signed [19:0]               y_hi;
  logic [62:0]                      sq_t;
  logic                             sq_ge;
  logic [31:0]                      root;
  logic [32:0]                      div_t;
  logic                             div_ge;
  logic [31:0]                      q32;
  logic signed [rpi_pkg::VAL_W-1:0] x_new;
  logic signed [rpi_pkg::EIG_W-1:0] eig_next;
  logic signed [48:0]               diff;
  logic [48:0]                      dmag;

  assign x_i   = xv[cmd.i];
  assign x_j   = xv[cmd.j];
  assign y_i   = yv[cmd.i];
  assign y_neg = y_i[rpi_pkg::Y_W-1];
  assign y_mag = y_neg ? rpi_pkg::Y_W'(-y_i) : rpi_pkg::Y_W'(y_i);

  // Common shift that places the largest magnitude in [2^28, 2^29).
  assign shr    = (lz <= 6'd22);
  assign sh_r   = 5'(6'd23 - lz);
  assign sh_l   = 5'(lz - 6'd23);
  assign m_next = shr ? 29'(y_mag >> sh_r) : 29'(y_mag << sh_l);

  assign y_lo  = {1'b0, y_i[31:0]};
  assign y_hi  = y_i[rpi_pkg::Y_W-1:32];
  assign p_mat = mat_q * x_j;
  assign p_lo  = x_i * y_lo;
  assign p_hi  = x_i * y_hi;
  assign p_sq  = m_r * m_r;

  assign sq_t  = sq_res + sq_bit;
  assign sq_ge = (sq_s >= sq_t);
  assign root  = sq_res[31:0];

  assign div_t  = {rem, feed};
  assign div_ge = (div_t >= {1'b0, root});
  assign q32    = {1'b0, quo};
  assign x_new  = y_neg ? $signed(32'(-q32)) : $signed(q32);

  assign eig_next = {{(rpi_pkg::EIG_W-44){lam[rpi_pkg::LAM_W-1]}}, lam[rpi_pkg::LAM_W-1:44]};
  assign diff     = {eig[rpi_pkg::EIG_W-1], eig} - {prev[rpi_pkg::EIG_W-1], prev};
  assign dmag     = diff[48] ? 49'(-diff) : 49'(diff);

  always_ff @(posedge clk) begin
    if (cmd.op == rpi_pkg::DP_LOAD_MAT) begin
      mat_mem[{cmd.i, cmd.j}] <= load_value;
    end
    mat_q <= mat_mem[{cmd.i, cmd.j}];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rpi_pkg::DP_LOAD_VEC: yv[cmd.i] <= rpi_pkg::Y_W'($signed(load_value));
      rpi_pkg::DP_CLR_RUN: begin
        eig   <= '0;
        prev  <= '0;
        count <= '0;
      end
      rpi_pkg::DP_NRM_CLR: begin
        orv <= '0;
        lz  <= '0;
        sum <= '0;
      end
      rpi_pkg::DP_NRM_OR: orv <= orv | y_mag;
      rpi_pkg::DP_LOD_STEP: begin
        if (!orv[rpi_pkg::Y_W-1]) begin
          orv <= orv << 1;
          lz  <= lz + 6'd1;
        end
      end
      rpi_pkg::DP_M_SET: m_r <= m_next;
      rpi_pkg::DP_SQ: prod <= $signed({6'd0, p_sq});
      rpi_pkg::DP_SQ_ACC: sum <= sum + prod[61:0];
      rpi_pkg::DP_SQRT_INIT: begin
        sq_s   <= {1'b0, sum};
        sq_res <= '0;
        sq_bit <= 63'(1) << 62;
      end
      rpi_pkg::DP_SQRT_STEP: begin
        if (sq_ge) begin
          sq_s   <= sq_s - sq_t;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      rpi_pkg::DP_DIV_INIT: begin
        rem  <= {4'd0, m_r[28:1]};
        quo  <= '0;
        feed <= m_r[0];
      end
      rpi_pkg::DP_DIV_STEP: begin
        if (div_ge) begin
          rem <= 32'(div_t - {1'b0, root});
        end else begin
          rem <= div_t[31:0];
        end
        quo  <= {quo[29:0], div_ge};
        feed <= 1'b0;
      end
      rpi_pkg::DP_DIV_WR: begin
        xv[cmd.i] <= x_new;
        yv[cmd.i] <= rpi_pkg::Y_W'(x_new);
      end
      rpi_pkg::DP_ZERO_WR: xv[cmd.i] <= '0;
      rpi_pkg::DP_MAT_RD: begin
        if (cmd.j == '0) begin
          acc <= '0;
        end
      end
      rpi_pkg::DP_MAT_MUL: prod <= p_mat;
      rpi_pkg::DP_MAT_ACC: acc <= acc + rpi_pkg::ACC_W'(prod);
      rpi_pkg::DP_Y_WR: yv[cmd.i] <= acc[rpi_pkg::ACC_W-1:16];
      rpi_pkg::DP_LAM_MLO: begin
        prod <= p_lo;
        if (cmd.i == '0) begin
          lam <= '0;
        end
      end
      rpi_pkg::DP_LAM_ALO: lam <= lam + rpi_pkg::LAM_W'(prod);
      rpi_pkg::DP_LAM_MHI: prod <= p_hi;
      rpi_pkg::DP_LAM_AHI: lam <= lam + (rpi_pkg::LAM_W'(prod) <<< 32);
      rpi_pkg::DP_EIG: eig <= eig_next;
      rpi_pkg::DP_ERR: begin
        err_ok <= (dmag <= 49'(tol));
        prev   <= eig;
        count  <= count + 7'd1;
      end
      default: ;
    endcase
  end

  assign stat.orv_zero = (orv == '0);
  assign stat.orv_msb  = orv[rpi_pkg::Y_W-1];
  assign stat.err_ok   = err_ok;
  assign stat.count    = count;
  assign x_out         = x_i;
  assign eig_out       = eig;

endmodule

`default_nettype wire

// ----- sv/rpi_ctrl.sv -----
// Controller of the power iteration unit: sequences loads, normalization,
// matrix-vector product, Rayleigh quotient and result output. Depends on rpi_pkg.
`default_nettype none

module rpi_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_valid,
  output logic                       s_ready,
  input  logic [1:0]                 func,
  input  logic [rpi_pkg::IDX_W-1:0]  row,
  input  logic [rpi_pkg::IDX_W-1:0]  col,
  input  logic [rpi_pkg::IDX_W-1:0]  nm1,
  input  logic [rpi_pkg::CNT_W-1:0]  limit,
  input  rpi_pkg::stat_t             stat,
  output rpi_pkg::cmd_t              cmd,
  output logic                       m_valid,
  input  logic                       m_ready,
  output logic [rpi_pkg::IDX_W-1:0]  out_index,
  output logic [1:0]                 out_status,
  output logic                       out_last
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_NCLR   = 16'h0002,
    S_NOR    = 16'h0004,
    S_NCHK   = 16'h0008,
    S_LOD    = 16'h0010,
    S_SQ     = 16'h0020,
    S_SQI    = 16'h0040,
    S_SQRT   = 16'h0080,
    S_DIV    = 16'h0100,
    S_ZERO   = 16'h0200,
    S_DECIDE = 16'h0400,
    S_MV     = 16'h0800,
    S_LAM    = 16'h1000,
    S_EIG    = 16'h2000,
    S_ERR    = 16'h4000,
    S_EMIT   = 16'h8000
  } state_t;

  state_t                     state, state_next;
  logic [rpi_pkg::IDX_W-1:0]  i, i_next;
  logic [rpi_pkg::IDX_W-1:0]  j, j_next;
  logic [1:0]                 ph, ph_next;
  logic [4:0]                 step, step_next;
  logic                       init_mode, init_mode_next;
  logic [1:0]                 status, status_next;
  logic                       i_last;

  assign i_last = (i == nm1);

  always_comb begin
    state_next     = state;
    i_next         = i;
    j_next         = j;
    ph_next        = ph;
    step_next      = step;
    init_mode_next = init_mode;
    status_next    = status;
    cmd.op         = rpi_pkg::DP_NOP;
    cmd.i          = i;
    cmd.j          = j;
    case (state)
      S_IDLE: begin
        if (s_valid) begin
          case (func)
            rpi_pkg::FN_MAT: begin
              cmd.op = rpi_pkg::DP_LOAD_MAT;
              cmd.i  = row;
              cmd.j  = col;
            end
            rpi_pkg::FN_VEC: begin
              cmd.op = rpi_pkg::DP_LOAD_VEC;
              cmd.i  = row;
            end
            rpi_pkg::FN_START: begin
              cmd.op         = rpi_pkg::DP_CLR_RUN;
              init_mode_next = 1'b1;
              state_next     = S_NCLR;
            end
            default: ;
          endcase
        end
      end
      S_NCLR: begin
        cmd.op     = rpi_pkg::DP_NRM_CLR;
        i_next     = '0;
        state_next = S_NOR;
      end
      S_NOR: begin
        cmd.op = rpi_pkg::DP_NRM_OR;
        if (i_last) begin
          state_next = S_NCHK;
        end else begin
          i_next = i + 4'd1;
        end
      end
      S_NCHK: begin
        i_next     = '0;
        ph_next    = '0;
        state_next = stat.orv_zero ? S_ZERO : S_LOD;
      end
      S_LOD: begin
        if (stat.orv_msb) begin
          state_next = S_SQ;
        end else begin
          cmd.op = rpi_pkg::DP_LOD_STEP;
        end
      end
      S_SQ: begin
        case (ph)
          2'd0: begin
            cmd.op  = rpi_pkg::DP_M_SET;
            ph_next = 2'd1;
          end
          2'd1: begin
            cmd.op  = rpi_pkg::DP_SQ;
            ph_next = 2'd2;
          end
          default: begin
            cmd.op  = rpi_pkg::DP_SQ_ACC;
            ph_next = 2'd0;
            if (i_last) begin
              state_next = S_SQI;
            end else begin
              i_next = i + 4'd1;
            end
          end
        endcase
      end
      S_SQI: begin
        cmd.op     = rpi_pkg::DP_SQRT_INIT;
        step_next  = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op    = rpi_pkg::DP_SQRT_STEP;
        step_next = step + 5'd1;
        if (step == 5'd31) begin
          i_next     = '0;
          ph_next    = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        case (ph)
          2'd0: begin
            cmd.op  = rpi_pkg::DP_M_SET;
            ph_next = 2'd1;
          end
          2'd1: begin
            cmd.op    = rpi_pkg::DP_DIV_INIT;
            step_next = '0;
            ph_next   = 2'd2;
          end
          2'd2: begin
            cmd.op    = rpi_pkg::DP_DIV_STEP;
            step_next = step + 5'd1;
            if (step == 5'd30) begin
              ph_next = 2'd3;
            end
          end
          default: begin
            cmd.op  = rpi_pkg::DP_DIV_WR;
            ph_next = 2'd0;
            if (i_last) begin
              state_next = S_DECIDE;
            end else begin
              i_next = i + 4'd1;
            end
          end
        endcase
      end
      S_ZERO: begin
        cmd.op = rpi_pkg::DP_ZERO_WR;
        if (i_last) begin
          state_next = S_DECIDE;
        end else begin
          i_next = i + 4'd1;
        end
      end
      S_DECIDE: begin
        i_next  = '0;
        j_next  = '0;
        ph_next = '0;
        if (stat.orv_zero) begin
          status_next = rpi_pkg::ST_ZERO;
          state_next  = S_EMIT;
        end else if (!init_mode && stat.err_ok) begin
          status_next = rpi_pkg::ST_CONV;
          state_next  = S_EMIT;
        end else if (!init_mode && stat.count >= limit) begin
          status_next = rpi_pkg::ST_LIMIT;
          state_next  = S_EMIT;
        end else begin
          init_mode_next = 1'b0;
          state_next     = S_MV;
        end
      end
      S_MV: begin
        case (ph)
          2'd0: begin
            cmd.op  = rpi_pkg::DP_MAT_RD;
            ph_next = 2'd1;
          end
          2'd1: begin
            cmd.op  = rpi_pkg::DP_MAT_MUL;
            ph_next = 2'd2;
          end
          2'd2: begin
            cmd.op = rpi_pkg::DP_MAT_ACC;
            if (j == nm1) begin
              ph_next = 2'd3;
            end else begin
              j_next  = j + 4'd1;
              ph_next = 2'd0;
            end
          end
          default: begin
            cmd.op  = rpi_pkg::DP_Y_WR;
            j_next  = '0;
            ph_next = 2'd0;
            if (i_last) begin
              i_next     = '0;
              state_next = S_LAM;
            end else begin
              i_next = i + 4'd1;
            end
          end
        endcase
      end
      S_LAM: begin
        ph_next = ph + 2'd1;
        case (ph)
          2'd0: cmd.op = rpi_pkg::DP_LAM_MLO;
          2'd1: cmd.op = rpi_pkg::DP_LAM_ALO;
          2'd2: cmd.op = rpi_pkg::DP_LAM_MHI;
          default: begin
            cmd.op = rpi_pkg::DP_LAM_AHI;
            if (i_last) begin
              state_next = S_EIG;
            end else begin
              i_next = i + 4'd1;
            end
          end
        endcase
      end
      S_EIG: begin
        cmd.op     = rpi_pkg::DP_EIG;
        state_next = S_ERR;
      end
      S_ERR: begin
        cmd.op     = rpi_pkg::DP_ERR;
        state_next = S_NCLR;
      end
      S_EMIT: begin
        if (m_ready) begin
          if (i_last) begin
            state_next = S_IDLE;
          end else begin
            i_next = i + 4'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      i         <= '0;
      j         <= '0;
      ph        <= '0;
      step      <= '0;
      init_mode <= 1'b0;
      status    <= rpi_pkg::ST_CONV;
    end else begin
      state     <= state_next;
      i         <= i_next;
      j         <= j_next;
      ph        <= ph_next;
      step      <= step_next;
      init_mode <= init_mode_next;
      status    <= status_next;
    end
  end

  assign s_ready    = (state == S_IDLE);
  assign m_valid    = (state == S_EMIT);
  assign out_index  = i;
  assign out_status = status;
  assign out_last   = i_last;

endmodule

`default_nettype wire

// ----- sv/rayleigh_power_iteration_unit.sv -----
// Top level of the Rayleigh power iteration unit: configuration registers,
// stream packing, controller and datapath. Depends on rpi_pkg, rpi_ctrl, rpi_dpath.
`default_nettype none

// The unit holds an n-by-n matrix and a start vector in Q16.16, loaded one
// element per input item, and on a start item finds the dominant eigenpair by
// power iteration: it normalizes the vector to Q2.30, then repeats y = A x,
// lambda = x . y, x = y / |y| until lambda changes by no more than the
// tolerance or the iteration limit is reached, and then sends n result items
// carrying each vector element, the eigenvalue, the iteration count and a
// status. Items are handled one at a time, and the input is not ready while
// a start item is being worked or its results are being sent. The
// normalization uses a serial leading-one search, a 32-step square root and a
// 31-step restoring divide per element. In the matrix-vector product each
// matrix element is read, multiplied and accumulated in separate steps,
// because the matrix sits in a single-port memory with a registered read and
// each product is registered before it is added. Configuration writes are
// taken in any cycle and should only be made while the unit is idle.

module rayleigh_power_iteration_unit (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // row [3:0], col [7:4], value [39:8]
  input  logic [1:0]  s_tuser,   // func [1:0]
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // index [3:0], vector_value [35:4],
                                 // eigenvalue [83:36], iterations [90:84], zero fill
  output logic [1:0]  m_tuser,   // status [1:0]
  output logic        m_tlast,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [rpi_pkg::SIZE_W-1:0] size_in_use;
  logic [31:0]                tolerance;
  logic [rpi_pkg::CNT_W-1:0]  iteration_limit;
  logic [rpi_pkg::IDX_W-1:0]  nm1;

  rpi_pkg::cmd_t                      cmd;
  rpi_pkg::stat_t                     stat;
  logic signed [rpi_pkg::VAL_W-1:0]   x_out;
  logic signed [rpi_pkg::EIG_W-1:0]   eig_out;
  logic [rpi_pkg::IDX_W-1:0]          out_index;
  logic [1:0]                         out_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use     <= 5'd16;
      tolerance       <= 32'd1;
      iteration_limit <= 7'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpi_pkg::CFG_SIZE:  size_in_use     <= cfg_data[rpi_pkg::SIZE_W-1:0];
        rpi_pkg::CFG_TOL:   tolerance       <= cfg_data;
        rpi_pkg::CFG_LIMIT: iteration_limit <= cfg_data[rpi_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero acts as one; sizes past the matrix store are clamped.
  always_comb begin
    if (size_in_use == '0) begin
      nm1 = '0;
    end else if (size_in_use > rpi_pkg::SIZE_W'(rpi_pkg::MAX_DIM)) begin
      nm1 = rpi_pkg::IDX_W'(rpi_pkg::MAX_DIM - 1);
    end else begin
      nm1 = rpi_pkg::IDX_W'(size_in_use - 5'd1);
    end
  end

  rpi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .func       (s_tuser),
    .row        (s_tdata[3:0]),
    .col        (s_tdata[7:4]),
    .nm1        (nm1),
    .limit      (iteration_limit),
    .stat       (stat),
    .cmd        (cmd),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .out_index  (out_index),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  rpi_dpath u_dpath (
    .clk        (clk),
    .cmd        (cmd),
    .load_value (s_tdata[39:8]),
    .tol        (tolerance),
    .stat       (stat),
    .x_out      (x_out),
    .eig_out    (eig_out)
  );

  assign m_tdata = {5'd0, stat.count, eig_out, x_out, out_index};
  assign m_tuser = out_status;

`ifndef NO_ASSERTIONS
  // Items are worked one at a time: no input is taken while results are out.
  a_no_accept_during_output: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while results are pending");

  // The last result of a run carries the last index in use.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[3:0] == nm1))
    else $error("tlast on wrong index");

  // A converged or limited run has made at least one iteration.
  a_iter_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == rpi_pkg::ST_CONV || m_tuser == rpi_pkg::ST_LIMIT))
      |-> (m_tdata[90:84] != 7'd0))
    else $error("non-zero-norm result with no iterations");
`endif

endmodule

`default_nettype wire
